FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions with and without a reset guard.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define DMF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/dmf_pkg.sv
// ---------------------------------------------------------------------------
// dmf_pkg
// Types and constants shared by the delimiter message framer modules.
// ---------------------------------------------------------------------------
package dmf_pkg;

    localparam int APB_AW = 5;
    localparam int APB_DW = 64;

    typedef enum logic [1:0] {
        REG_DELIM = 2'd0,
        REG_DLEN  = 2'd1,
        REG_CAP   = 2'd2,
        REG_NONE  = 2'd3
    } t_reg_idx;

    localparam logic [63:0] DELIM_RST = 64'd10;
    localparam logic [3:0]  DLEN_RST  = 4'd1;
    localparam logic [6:0]  CAP_RST   = 7'd64;

    typedef struct packed {
        logic [63:0] delim;
        logic [3:0]  dlen;
        logic [6:0]  cap;
    } t_cfg;

endpackage

FILE: sv/dmf_regs.sv
// ---------------------------------------------------------------------------
// dmf_regs
// Configuration register file behind the APB-style port.
// ---------------------------------------------------------------------------
module dmf_regs
    import dmf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output logic              o_pready,
    output t_cfg              o_cfg
);

    logic [63:0] r_delim;
    logic [3:0]  r_dlen;
    logic [6:0]  r_cap;
    t_reg_idx    idx;
    logic        wr;

    assign idx      = t_reg_idx'(i_paddr[4:3]);
    assign wr       = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RST;
            r_dlen  <= DLEN_RST;
            r_cap   <= CAP_RST;
        end else if (wr) begin
            case (idx)
                REG_DELIM: r_delim <= i_pwdata;
                REG_DLEN:  r_dlen  <= i_pwdata[3:0];
                REG_CAP:   r_cap   <= i_pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_DELIM: o_prdata = r_delim;
            REG_DLEN:  o_prdata = APB_DW'(r_dlen);
            REG_CAP:   o_prdata = APB_DW'(r_cap);
            default:   o_prdata = '0;
        endcase
    end

    assign o_cfg = '{delim: r_delim, dlen: r_dlen, cap: r_cap};

endmodule

FILE: sv/dmf_store.sv
// ---------------------------------------------------------------------------
// dmf_store
// Message byte store: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module dmf_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

FILE: sv/dmf_ctrl.sv
// ---------------------------------------------------------------------------
// dmf_ctrl
// Fill count, delimiter match and the store walk that emits a message.
// ---------------------------------------------------------------------------
module dmf_ctrl
    import dmf_pkg::*;
#(
    parameter int STORE_DEPTH         = 64,
    parameter int MAX_DELIMITER_BYTES = 8,
    parameter int AW                  = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_rx_valid,
    output logic          o_rx_ready,
    input  logic [7:0]    i_rx_byte,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_payload_byte,
    output logic          o_last_of_message,
    output logic          o_empty_message,
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_waddr,
    output logic [AW-1:0] o_mem_raddr,
    input  logic [7:0]    i_mem_rdata
);

    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int EW = (CW > 7) ? CW : 7;
    localparam int LW = (CW > 4) ? CW : 4;
    localparam int RW = 8 * MAX_DELIMITER_BYTES;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_WAIT
    } t_state;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_fill, n_fill;
    logic [RW-1:0]  r_recent, n_recent;
    logic [CW-1:0]  r_len, n_len;
    logic [CW-1:0]  r_idx, n_idx;
    logic           r_valid, n_valid;
    logic [7:0]     r_pb, n_pb;
    logic           r_last, n_last;
    logic           r_empty, n_empty;

    logic [EW-1:0]  cap_eff;
    logic [3:0]     dlen_eff;
    logic [CW-1:0]  fill_inc;
    logic [CW-1:0]  fill_new;
    logic [RW-1:0]  recent_new;
    logic [MAX_DELIMITER_BYTES-1:0] byte_ok;
    logic           hit;
    logic [CW-1:0]  pay_len;

    always_comb begin
        if (EW'(i_cfg.cap) > EW'(STORE_DEPTH)) begin
            cap_eff = EW'(STORE_DEPTH);
        end else begin
            cap_eff = EW'(i_cfg.cap);
        end
        if (i_cfg.dlen == 4'd0) begin
            dlen_eff = 4'd1;
        end else if (i_cfg.dlen > 4'(MAX_DELIMITER_BYTES)) begin
            dlen_eff = 4'(MAX_DELIMITER_BYTES);
        end else begin
            dlen_eff = i_cfg.dlen;
        end
    end

    always_comb begin
        fill_inc   = r_fill + 1'b1;
        fill_new   = (EW'(fill_inc) >= cap_eff) ? '0 : fill_inc;
        recent_new = (r_recent << 8) | RW'(i_rx_byte);
        for (int j = 0; j < MAX_DELIMITER_BYTES; j++) begin
            byte_ok[j] = (4'(j) >= dlen_eff) ||
                         (recent_new[8*j +: 8] == i_cfg.delim[8*j +: 8]);
        end
        hit     = (LW'(fill_new) >= LW'(dlen_eff)) && (&byte_ok);
        pay_len = CW'(LW'(fill_new) - LW'(dlen_eff));
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_recent = r_recent;
        n_len    = r_len;
        n_idx    = r_idx;
        n_valid  = r_valid;
        n_pb     = r_pb;
        n_last   = r_last;
        n_empty  = r_empty;
        o_mem_we = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_rx_valid) begin
                    o_mem_we = 1'b1;
                    n_recent = recent_new;
                    n_fill   = fill_new;
                    if (hit) begin
                        n_fill = '0;
                        if (pay_len == '0) begin
                            n_pb    = 8'd0;
                            n_last  = 1'b1;
                            n_empty = 1'b1;
                            n_valid = 1'b1;
                            n_state = S_WAIT;
                        end else begin
                            n_len   = pay_len;
                            n_idx   = '0;
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_pb    = i_mem_rdata;
                n_last  = (r_idx + 1'b1) == r_len;
                n_empty = 1'b0;
                n_valid = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_out_ready) begin
                    n_valid = 1'b0;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_recent <= '0;
            r_valid  <= 1'b0;
            r_len    <= '0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_recent <= n_recent;
            r_valid  <= n_valid;
            r_len    <= n_len;
            r_idx    <= n_idx;
            r_pb     <= n_pb;
            r_last   <= n_last;
            r_empty  <= n_empty;
        end
    end

    assign o_rx_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_valid;
    assign o_payload_byte    = r_pb;
    assign o_last_of_message = r_last;
    assign o_empty_message   = r_empty;
    assign o_mem_waddr       = r_fill[AW-1:0];
    assign o_mem_raddr       = r_idx[AW-1:0];

endmodule

FILE: sv/delimiter_message_framer.sv
// ---------------------------------------------------------------------------
// delimiter_message_framer
// Gathers received bytes into a message store and emits each message once
// its delimiter has arrived.
// ---------------------------------------------------------------------------
// A byte that does not complete a message is taken while idle, and the next
// byte can follow in the cycle after. When a byte completes a message, the
// input is held off while the store is walked through its single read port:
// each payload byte is read, loaded and presented, and held while the output
// side stalls; an empty message takes one result. The user must write
// configuration through the APB port while the block is idle (not enforced).
module delimiter_message_framer
    import dmf_pkg::*;
#(
    parameter int STORE_DEPTH         = 64,
    parameter int MAX_DELIMITER_BYTES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [7:0]        i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_payload_byte,
    output logic              o_last_of_message,
    output logic              o_empty_message
);

    localparam int AW = $clog2(STORE_DEPTH);

    t_cfg          cfg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    dmf_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    dmf_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_rx_byte),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    dmf_ctrl #(
        .STORE_DEPTH         (STORE_DEPTH),
        .MAX_DELIMITER_BYTES (MAX_DELIMITER_BYTES),
        .AW                  (AW)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_rx_valid        (i_rx_valid),
        .o_rx_ready        (o_rx_ready),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_payload_byte    (o_payload_byte),
        .o_last_of_message (o_last_of_message),
        .o_empty_message   (o_empty_message),
        .o_mem_we          (mem_we),
        .o_mem_waddr       (mem_waddr),
        .o_mem_raddr       (mem_raddr),
        .i_mem_rdata       (mem_rdata)
    );

endmodule

FILE: sv/dmf_checker.sv
// ---------------------------------------------------------------------------
// dmf_checker
// Port-level checks for the delimiter message framer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dmf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       pready,
    input logic       o_rx_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_payload_byte,
    input logic       o_last_of_message,
    input logic       o_empty_message
);

    `DMF_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_payload_byte) && $stable(o_last_of_message), "Output item changed while stalled.")
    `DMF_ASSERT(a_empty_form, i_clk, i_rst_n, o_out_valid && o_empty_message |-> o_last_of_message && (o_payload_byte == 8'd0), "Empty message item is malformed.")
    `DMF_ASSERT(a_one_side, i_clk, i_rst_n, o_out_valid |-> !o_rx_ready, "Input taken while a message item is pending.")
    `DMF_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid && pready, "Output valid after reset.")

endmodule

bind delimiter_message_framer dmf_checker u_dmf_checker (.*);

FILE: tb/sv/delimiter_message_framer_tb.sv
// ---------------------------------------------------------------------------
// delimiter_message_framer_tb
// Self-checking testbench for the delimiter message framer. A table of
// directed items and register writes covers the reset state, the extremes
// and the special cases, and random traffic follows: mostly well-formed
// messages under several settings, mixed with noise and broken delimiters.
// An internal framing predictor computes the expected output items, and each
// output item is compared field by field with the oldest expectation.
// ---------------------------------------------------------------------------
module delimiter_message_framer_tb;
    import dmf_pkg::*;

    localparam int STORE_DEPTH    = 64;
    localparam int MAX_DELIM      = 8;
    localparam int TOTAL_ITEMS    = 210;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } t_frame_beat;

    typedef enum logic {
        STEP_WRITE,
        STEP_BYTE
    } t_step_kind;

    typedef struct packed {
        t_step_kind  kind;
        t_reg_idx    target;
        logic [63:0] value;
        logic        typed;
        t_frame_beat want;
    } t_stim_row;

    localparam int NUM_ROWS = 36;
    localparam t_stim_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_000A, 1'b1, '{8'h00, 1'b1, 1'b1}},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_0000, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_00FF, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_000A, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_0041, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_000A, 1'b1, '{8'h41, 1'b1, 1'b0}},
        '{STEP_WRITE, REG_NONE,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{STEP_WRITE, REG_DLEN,  64'hFFFF_FFFF_FFFF_FFF0, 1'b0, '0},
        '{STEP_WRITE, REG_DELIM, 64'hFFFF_FFFF_FFFF_FF80, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_0080, 1'b1, '{8'h00, 1'b1, 1'b1}},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_007F, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_0080, 1'b1, '{8'h7F, 1'b1, 1'b0}},
        '{STEP_WRITE, REG_DLEN,  64'h0000_0000_0000_000F, 1'b0, '0},
        '{STEP_WRITE, REG_DELIM, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
        '{STEP_WRITE, REG_CAP,   64'h0000_0000_0000_007F, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_0001, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_0023, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_0045, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_0067, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_0089, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_00AB, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_00CD, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_00EF, 1'b1, '{8'h00, 1'b1, 1'b1}},
        '{STEP_WRITE, REG_DLEN,  64'h0000_0000_0000_0002, 1'b0, '0},
        '{STEP_WRITE, REG_DELIM, 64'hA5A5_A5A5_A5A5_0D0A, 1'b0, '0},
        '{STEP_WRITE, REG_CAP,   64'h0000_0000_0000_0002, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_000D, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_000A, 1'b0, '0},
        '{STEP_WRITE, REG_DLEN,  64'h0000_0000_0000_0001, 1'b0, '0},
        '{STEP_WRITE, REG_CAP,   64'h0000_0000_0000_0001, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_000A, 1'b0, '0},
        '{STEP_WRITE, REG_CAP,   64'h0000_0000_0000_0000, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_000A, 1'b0, '0},
        '{STEP_WRITE, REG_CAP,   64'h0000_0000_0000_0003, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_0055, 1'b0, '0},
        '{STEP_BYTE,  REG_NONE,  64'h0000_0000_0000_000A, 1'b1, '{8'h55, 1'b1, 1'b0}}
    };

    logic              i_clk             = 1'b0;
    logic              i_rst_n           = 1'b0;
    logic              psel              = 1'b0;
    logic              penable           = 1'b0;
    logic              pwrite            = 1'b0;
    logic [APB_AW-1:0] paddr             = '0;
    logic [APB_DW-1:0] pwdata            = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_rx_valid        = 1'b0;
    logic              o_rx_ready;
    logic [7:0]        i_rx_byte         = '0;
    logic              o_out_valid;
    logic              i_out_ready       = 1'b0;
    logic [7:0]        o_payload_byte;
    logic              o_last_of_message;
    logic              o_empty_message;

    t_cfg        shadow_cfg;
    logic [7:0]  msg_store [STORE_DEPTH];
    int unsigned fill_count;
    logic [63:0] recent_rx;
    t_frame_beat framed_beats [$];
    t_frame_beat awaited_beats [$];
    t_frame_beat head_beat;

    int   mismatches   = 0;
    int   rx_accepted  = 0;
    int   quiet_cycles = 0;
    int   stall_left   = 0;
    int   hold_left    = 0;
    logic hold_pending = 1'b0;
    logic idle_on      = 1'b1;

    delimiter_message_framer #(
        .STORE_DEPTH        (STORE_DEPTH),
        .MAX_DELIMITER_BYTES(MAX_DELIM)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_rx_valid       (i_rx_valid),
        .o_rx_ready       (o_rx_ready),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_payload_byte   (o_payload_byte),
        .o_last_of_message(o_last_of_message),
        .o_empty_message  (o_empty_message)
    );

    always #5 i_clk = ~i_clk;

    function automatic int eff_dlen(input logic [3:0] raw);
        if (raw == 4'd0) return 1;
        if (raw > MAX_DELIM) return MAX_DELIM;
        return int'(raw);
    endfunction

    function automatic int eff_cap(input logic [6:0] raw);
        if (raw > STORE_DEPTH) return STORE_DEPTH;
        return int'(raw);
    endfunction

    function automatic void absorb_byte(input logic [7:0] value);
        int          cap;
        int          dlen;
        int          body;
        logic [63:0] mask;
        framed_beats.delete();
        cap  = eff_cap(shadow_cfg.cap);
        dlen = eff_dlen(shadow_cfg.dlen);
        msg_store[fill_count] = value;
        recent_rx = {recent_rx[55:0], value};
        fill_count++;
        if (fill_count >= cap) fill_count = 0;
        if (int'(fill_count) < dlen) return;
        mask = {64{1'b1}} >> (64 - 8 * dlen);
        if ((recent_rx & mask) != (shadow_cfg.delim & mask)) return;
        body = int'(fill_count) - dlen;
        fill_count = 0;
        if (body == 0) framed_beats.push_back('{8'h00, 1'b1, 1'b1});
        for (int k = 0; k < body; k++) begin
            framed_beats.push_back('{msg_store[k], (k + 1 == body), 1'b0});
        end
    endfunction

    task automatic offer_byte(input logic [7:0] value, input logic typed,
                              input t_frame_beat want);
        i_rx_valid <= 1'b1;
        i_rx_byte  <= value;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        absorb_byte(value);
        if (typed) begin
            awaited_beats.push_back(want);
        end else begin
            foreach (framed_beats[k]) awaited_beats.push_back(framed_beats[k]);
        end
        rx_accepted++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_rx_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic send_delimiter(input int count);
        int dlen;
        dlen = eff_dlen(shadow_cfg.dlen);
        for (int j = dlen - 1; j >= dlen - count; j--) begin
            offer_byte(shadow_cfg.delim[8*j +: 8], 1'b0, '0);
        end
    endtask

    task automatic drain_block();
        i_rx_valid <= 1'b0;
        while (awaited_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx target, input logic [63:0] value);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {target, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (target)
            REG_DELIM: shadow_cfg.delim = value;
            REG_DLEN:  shadow_cfg.dlen  = value[3:0];
            REG_CAP:   shadow_cfg.cap   = value[6:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_beats.size() == 0) begin
                $display("%0t: unexpected item: payload_byte %02h last %b empty %b",
                         $time, o_payload_byte, o_last_of_message, o_empty_message);
                mismatches++;
            end else begin
                head_beat = awaited_beats.pop_front();
                if (o_payload_byte !== head_beat.data) begin
                    $display("%0t: payload_byte expected %02h actual %02h",
                             $time, head_beat.data, o_payload_byte);
                    mismatches++;
                end
                if (o_last_of_message !== head_beat.last) begin
                    $display("%0t: last_of_message expected %b actual %b",
                             $time, head_beat.last, o_last_of_message);
                    mismatches++;
                end
                if (o_empty_message !== head_beat.empty) begin
                    $display("%0t: empty_message expected %b actual %b",
                             $time, head_beat.empty, o_empty_message);
                    mismatches++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 13);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_rx_valid && o_rx_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("delimiter_message_framer regression: fail");
        $finish;
    end

    initial begin
        t_stim_row   row;
        logic [63:0] reg_word;
        logic [3:0]  dlen_raw;
        logic [6:0]  cap_raw;
        int          phase;
        int          phase_end;
        int          pick;
        int          dlen;
        int          room;
        int          len;
        shadow_cfg = '{DELIM_RST, DLEN_RST, CAP_RST};
        fill_count = 0;
        recent_rx  = '0;
        foreach (msg_store[k]) msg_store[k] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.kind == STEP_WRITE) begin
                drain_block();
                write_reg(row.target, row.value);
            end else begin
                offer_byte(row.value[7:0], row.typed, row.want);
            end
        end

        phase = 0;
        while (rx_accepted < TOTAL_ITEMS) begin
            drain_block();
            idle_on = (phase % 3 != 2) && (rx_accepted < TOTAL_ITEMS - 40);
            case (phase)
                0: begin
                    dlen_raw = 4'd8;
                    cap_raw  = 7'd64;
                end
                1: begin
                    dlen_raw = 4'd1;
                    cap_raw  = 7'd2;
                end
                2: begin
                    dlen_raw = 4'd1;
                    cap_raw  = 7'd64;
                end
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        dlen_raw = ($urandom_range(0, 1) == 0) ? 4'd0
                                                               : 4'($urandom_range(9, 15));
                    end else begin
                        dlen_raw = 4'($urandom_range(1, MAX_DELIM));
                    end
                    if ($urandom_range(0, 4) == 0) begin
                        cap_raw = 7'($urandom_range(STORE_DEPTH + 1, 127));
                    end else begin
                        cap_raw = 7'($urandom_range(eff_dlen(dlen_raw) + 2, STORE_DEPTH));
                    end
                end
            endcase
            reg_word = {$urandom, $urandom};
            write_reg(REG_DELIM, reg_word);
            reg_word = {$urandom, $urandom};
            reg_word[3:0] = dlen_raw;
            write_reg(REG_DLEN, reg_word);
            reg_word = {$urandom, $urandom};
            reg_word[6:0] = cap_raw;
            write_reg(REG_CAP, reg_word);
            if (phase == 3) hold_pending = 1'b1;

            phase_end = rx_accepted + 25;
            while (rx_accepted < phase_end) begin
                pick = $urandom_range(0, 9);
                dlen = eff_dlen(shadow_cfg.dlen);
                if (pick < 7) begin
                    room = eff_cap(shadow_cfg.cap) - dlen - 1 - int'(fill_count);
                    if (room <= 0) begin
                        len = 0;
                    end else if ($urandom_range(0, 7) == 0) begin
                        len = room;
                    end else begin
                        len = $urandom_range(0, (room < 6) ? room : 6);
                    end
                    repeat (len) offer_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                    send_delimiter(dlen);
                end else if (pick < 9) begin
                    repeat ($urandom_range(1, 5)) begin
                        offer_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                    end
                end else begin
                    send_delimiter(dlen - 1);
                    offer_byte(shadow_cfg.delim[7:0] ^ (8'h01 << $urandom_range(0, 7)),
                               1'b0, '0);
                end
            end
            phase++;
        end

        drain_block();
        if (mismatches == 0 && awaited_beats.size() == 0) begin
            $display("delimiter_message_framer regression: pass");
        end else begin
            $display("delimiter_message_framer regression: fail");
        end
        $finish;
    end

endmodule

FILE: delimiter_message_framer.f
+incdir+sv
sv/dmf_pkg.sv
sv/dmf_regs.sv
sv/dmf_store.sv
sv/dmf_ctrl.sv
sv/delimiter_message_framer.sv
sv/dmf_checker.sv
tb/sv/delimiter_message_framer_tb.sv
